/* hw/rtl/ps2kd_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 set-1 key decoder package
// Scancode constants, event codes and the key-to-ASCII tables.
// ----------------------------------------------------------------------------
package ps2kd_pkg;

    localparam int unsigned SCAN_W  = 8;
    localparam int unsigned EVENT_W = 4;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned LED_W   = 3;

    localparam logic [SCAN_W-1:0] SC_PREFIX     = 8'hE0;
    localparam logic [SCAN_W-1:0] SC_LSHIFT     = 8'h2A;
    localparam logic [SCAN_W-1:0] SC_RSHIFT     = 8'h36;
    localparam logic [SCAN_W-1:0] SC_CAPS       = 8'h3A;
    localparam logic [SCAN_W-1:0] SC_BACKSPACE  = 8'h0E;
    localparam logic [SCAN_W-1:0] SC_ENTER      = 8'h1C;
    localparam logic [SCAN_W-1:0] SC_LWIN       = 8'h5B;
    localparam logic [SCAN_W-1:0] SC_RWIN       = 8'h5C;
    localparam logic [SCAN_W-1:0] SC_UP         = 8'h48;
    localparam logic [SCAN_W-1:0] SC_DOWN       = 8'h50;
    localparam logic [SCAN_W-1:0] SC_LEFT       = 8'h4B;
    localparam logic [SCAN_W-1:0] SC_RIGHT      = 8'h4D;
    localparam int unsigned       SC_BREAK_BIT  = 7;

    localparam logic [LED_W-1:0]  LED_CAPS      = 3'h4;
    localparam logic [LED_W-1:0]  LED_NONE      = 3'h0;
    localparam logic [CHAR_W-1:0] CHAR_NONE     = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CHAR_CASE_BIT = 7'h20;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 4'd0,
        EV_CHAR      = 4'd1,
        EV_BKSP      = 4'd2,
        EV_ENTER     = 4'd3,
        EV_CAPS      = 4'd4,
        EV_START     = 4'd5,
        EV_HIST_UP   = 4'd6,
        EV_HIST_DOWN = 4'd7,
        EV_CUR_UP    = 4'd8,
        EV_CUR_DOWN  = 4'd9,
        EV_CUR_LEFT  = 4'd10,
        EV_CUR_RIGHT = 4'd11
    } event_t;

    // Unshifted ASCII for the low 64 make codes; zero where no key maps.
    function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] code);
        logic [CHAR_W-1:0] c;
        c = CHAR_NONE;
        case (code)
            6'h02: c = 7'h31;
            6'h03: c = 7'h32;
            6'h04: c = 7'h33;
            6'h05: c = 7'h34;
            6'h06: c = 7'h35;
            6'h07: c = 7'h36;
            6'h08: c = 7'h37;
            6'h09: c = 7'h38;
            6'h0A: c = 7'h39;
            6'h0B: c = 7'h30;
            6'h0C: c = 7'h2D;
            6'h0D: c = 7'h3D;
            6'h10: c = 7'h71;
            6'h11: c = 7'h77;
            6'h12: c = 7'h65;
            6'h13: c = 7'h72;
            6'h14: c = 7'h74;
            6'h15: c = 7'h79;
            6'h16: c = 7'h75;
            6'h17: c = 7'h69;
            6'h18: c = 7'h6F;
            6'h19: c = 7'h70;
            6'h1A: c = 7'h5B;
            6'h1B: c = 7'h5D;
            6'h1E: c = 7'h61;
            6'h1F: c = 7'h73;
            6'h20: c = 7'h64;
            6'h21: c = 7'h66;
            6'h22: c = 7'h67;
            6'h23: c = 7'h68;
            6'h24: c = 7'h6A;
            6'h25: c = 7'h6B;
            6'h26: c = 7'h6C;
            6'h27: c = 7'h3B;
            6'h28: c = 7'h27;
            6'h29: c = 7'h60;
            6'h2B: c = 7'h5C;
            6'h2C: c = 7'h7A;
            6'h2D: c = 7'h78;
            6'h2E: c = 7'h63;
            6'h2F: c = 7'h76;
            6'h30: c = 7'h62;
            6'h31: c = 7'h6E;
            6'h32: c = 7'h6D;
            6'h33: c = 7'h2C;
            6'h34: c = 7'h2E;
            6'h35: c = 7'h2F;
            6'h39: c = 7'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // Shifted ASCII for the low 64 make codes; zero where no key maps.
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [5:0] code);
        logic [CHAR_W-1:0] c;
        c = CHAR_NONE;
        case (code)
            6'h02: c = 7'h21;
            6'h03: c = 7'h40;
            6'h04: c = 7'h23;
            6'h05: c = 7'h24;
            6'h06: c = 7'h25;
            6'h07: c = 7'h5E;
            6'h08: c = 7'h26;
            6'h09: c = 7'h2A;
            6'h0A: c = 7'h28;
            6'h0B: c = 7'h29;
            6'h0C: c = 7'h5F;
            6'h0D: c = 7'h2B;
            6'h10: c = 7'h51;
            6'h11: c = 7'h57;
            6'h12: c = 7'h45;
            6'h13: c = 7'h52;
            6'h14: c = 7'h54;
            6'h15: c = 7'h59;
            6'h16: c = 7'h55;
            6'h17: c = 7'h49;
            6'h18: c = 7'h4F;
            6'h19: c = 7'h50;
            6'h1A: c = 7'h7B;
            6'h1B: c = 7'h7D;
            6'h1E: c = 7'h41;
            6'h1F: c = 7'h53;
            6'h20: c = 7'h44;
            6'h21: c = 7'h46;
            6'h22: c = 7'h47;
            6'h23: c = 7'h48;
            6'h24: c = 7'h4A;
            6'h25: c = 7'h4B;
            6'h26: c = 7'h4C;
            6'h27: c = 7'h3A;
            6'h28: c = 7'h22;
            6'h29: c = 7'h7E;
            6'h2B: c = 7'h7C;
            6'h2C: c = 7'h5A;
            6'h2D: c = 7'h58;
            6'h2E: c = 7'h43;
            6'h2F: c = 7'h56;
            6'h30: c = 7'h42;
            6'h31: c = 7'h4E;
            6'h32: c = 7'h4D;
            6'h33: c = 7'h3C;
            6'h34: c = 7'h3E;
            6'h35: c = 7'h3F;
            6'h39: c = 7'h20;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/ps2_scancode_key_decoder.sv */
// ----------------------------------------------------------------------------
// PS/2 set-1 scancode key decoder
// Turns raw set-1 scancode bytes into key events, tracking shift, caps lock
// and the extended prefix.
// ----------------------------------------------------------------------------
// Usage:
// The scan channel (scan_valid, scan_stall, scan_byte) takes one raw scancode
// word per cycle while scan_stall is low. The key channel (key_valid,
// key_stall, event_res, char_code, led_bits) returns exactly one result word
// for every scancode word, in order, including words that decode to no event
// (event_res = none). An accepted word is held in the input register, decoded
// combinationally and stored in the result register that drives the key
// channel. Throughput is one word per cycle while key_stall is low, set by the
// single decode stage between the input and result registers.
// When the receiver holds key_stall, the result register keeps its word and
// the input register fills; once both are full, scan_stall rises in the same
// cycle, so no word is lost. The shift, caps and prefix flags change only
// when a word moves from the input register into the result register.
// Reset clears both valid flags and all three flags: shift released, caps
// lock off, no prefix pending.
// ----------------------------------------------------------------------------
module ps2_scancode_key_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             scan_valid,
    output logic                             scan_stall,
    input  logic [ps2kd_pkg::SCAN_W-1:0]     scan_byte,
    output logic                             key_valid,
    input  logic                             key_stall,
    output logic [ps2kd_pkg::EVENT_W-1:0]    event_res,
    output logic [ps2kd_pkg::CHAR_W-1:0]     char_code,
    output logic [ps2kd_pkg::LED_W-1:0]      led_bits
);

    logic                          in_valid_reg;
    logic [ps2kd_pkg::SCAN_W-1:0]  in_byte_reg;
    logic                          out_valid_reg;
    ps2kd_pkg::event_t             out_event_reg;
    logic [ps2kd_pkg::CHAR_W-1:0]  out_char_reg;
    logic [ps2kd_pkg::LED_W-1:0]   out_led_reg;

    logic                          shift_reg;
    logic                          shift_next;
    logic                          caps_reg;
    logic                          caps_next;
    logic                          prefix_reg;
    logic                          prefix_next;

    ps2kd_pkg::event_t             event_next;
    logic [ps2kd_pkg::CHAR_W-1:0]  char_next;
    logic [ps2kd_pkg::LED_W-1:0]   led_next;

    logic                          out_load;
    logic                          in_load;
    logic                          is_break;
    logic [ps2kd_pkg::SCAN_W-1:0]  rel_code;
    logic [ps2kd_pkg::CHAR_W-1:0]  base_char;
    logic [ps2kd_pkg::CHAR_W-1:0]  key_char;
    logic                          is_letter;

    // The result register takes a new word whenever the input register holds one and it is empty or drained.
    assign out_load   = in_valid_reg && (!out_valid_reg || !key_stall);
    assign in_load    = scan_valid && !scan_stall;
    assign scan_stall = in_valid_reg && !out_load;

    assign is_break  = in_byte_reg[ps2kd_pkg::SC_BREAK_BIT];
    assign rel_code  = {1'b0, in_byte_reg[ps2kd_pkg::SCAN_W-2:0]};

    // Only codes below 64 have a table entry.
    assign base_char = (in_byte_reg[7:6] == 2'b00)
                     ? ps2kd_pkg::plain_char(in_byte_reg[5:0]) : ps2kd_pkg::CHAR_NONE;

    assign is_letter = (base_char >= ps2kd_pkg::CHAR_LOWER_A)
                    && (base_char <= ps2kd_pkg::CHAR_LOWER_Z);

    always_comb
    begin
        key_char = ps2kd_pkg::CHAR_NONE;
        if (in_byte_reg[7:6] == 2'b00)
        begin
            if (is_letter)
            begin
                key_char = (caps_reg != shift_reg)
                         ? (base_char & ~ps2kd_pkg::CHAR_CASE_BIT) : base_char;
            end
            else if (shift_reg)
            begin
                key_char = ps2kd_pkg::shifted_char(in_byte_reg[5:0]);
            end
            else
            begin
                key_char = base_char;
            end
        end
    end

    always_comb
    begin
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        event_next  = ps2kd_pkg::EV_NONE;
        char_next   = ps2kd_pkg::CHAR_NONE;
        led_next    = ps2kd_pkg::LED_NONE;

        if (in_byte_reg == ps2kd_pkg::SC_PREFIX)
        begin
            prefix_next = 1'b1;
        end
        else if (prefix_reg)
        begin
            prefix_next = 1'b0;
            if (!is_break)
            begin
                if (in_byte_reg == ps2kd_pkg::SC_LWIN || in_byte_reg == ps2kd_pkg::SC_RWIN)
                begin
                    event_next = ps2kd_pkg::EV_START;
                end
                else if (shift_reg)
                begin
                    if (in_byte_reg == ps2kd_pkg::SC_UP)
                    begin
                        event_next = ps2kd_pkg::EV_HIST_UP;
                    end
                    else if (in_byte_reg == ps2kd_pkg::SC_DOWN)
                    begin
                        event_next = ps2kd_pkg::EV_HIST_DOWN;
                    end
                end
                else
                begin
                    if (in_byte_reg == ps2kd_pkg::SC_UP)
                    begin
                        event_next = ps2kd_pkg::EV_CUR_UP;
                    end
                    else if (in_byte_reg == ps2kd_pkg::SC_DOWN)
                    begin
                        event_next = ps2kd_pkg::EV_CUR_DOWN;
                    end
                    else if (in_byte_reg == ps2kd_pkg::SC_LEFT)
                    begin
                        event_next = ps2kd_pkg::EV_CUR_LEFT;
                    end
                    else if (in_byte_reg == ps2kd_pkg::SC_RIGHT)
                    begin
                        event_next = ps2kd_pkg::EV_CUR_RIGHT;
                    end
                end
            end
        end
        else if (is_break)
        begin
            if (rel_code == ps2kd_pkg::SC_LSHIFT || rel_code == ps2kd_pkg::SC_RSHIFT)
            begin
                shift_next = 1'b0;
            end
        end
        else if (in_byte_reg == ps2kd_pkg::SC_LSHIFT || in_byte_reg == ps2kd_pkg::SC_RSHIFT)
        begin
            shift_next = 1'b1;
        end
        else if (in_byte_reg == ps2kd_pkg::SC_CAPS)
        begin
            caps_next  = !caps_reg;
            event_next = ps2kd_pkg::EV_CAPS;
            led_next   = caps_reg ? ps2kd_pkg::LED_NONE : ps2kd_pkg::LED_CAPS;
        end
        else if (in_byte_reg == ps2kd_pkg::SC_BACKSPACE)
        begin
            event_next = ps2kd_pkg::EV_BKSP;
        end
        else if (in_byte_reg == ps2kd_pkg::SC_ENTER)
        begin
            event_next = ps2kd_pkg::EV_ENTER;
        end
        else if (key_char != ps2kd_pkg::CHAR_NONE)
        begin
            event_next = ps2kd_pkg::EV_CHAR;
            char_next  = key_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            prefix_reg    <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                shift_reg     <= shift_next;
                caps_reg      <= caps_next;
                prefix_reg    <= prefix_next;
            end
            else if (!key_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= scan_byte;
        end
        if (out_load)
        begin
            out_event_reg <= event_next;
            out_char_reg  <= char_next;
            out_led_reg   <= led_next;
        end
    end

    assign key_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign char_code = out_char_reg;
    assign led_bits  = out_led_reg;

endmodule
